### rtl/qnbc_pkg.sv
// ----------------------------------------------------------------------------
// Quadrant naive Bayes classifier package
// Shared constants, command and region codes, and word types.
// ----------------------------------------------------------------------------
package qnbc_pkg;

  localparam int POINTS_PER_CLASS = 1024;
  localparam int COORD_BITS       = 16;
  localparam int ADDR_BITS        = $clog2(POINTS_PER_CLASS);
  localparam int CNT_BITS         = ADDR_BITS + 1;

  localparam logic [1:0] CMD_LOAD     = 2'd0;
  localparam logic [1:0] CMD_CLASSIFY = 2'd1;
  localparam logic [1:0] CMD_CLEAR    = 2'd2;

  localparam logic [1:0] REGION_UPPER_LEFT  = 2'd0;
  localparam logic [1:0] REGION_UPPER_RIGHT = 2'd1;
  localparam logic [1:0] REGION_LOWER_RIGHT = 2'd2;
  localparam logic [1:0] REGION_OTHER       = 2'd3;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [CNT_BITS-1:0]          cnt_t;
  typedef logic [ADDR_BITS-1:0]         addr_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  typedef struct packed {
    coord_t xmin;
    coord_t xmax;
    coord_t ymin;
    coord_t ymax;
  } box_t;

  typedef struct packed {
    logic [1:0] command;
    coord_t     coord_x;
    coord_t     coord_y;
    logic       class_label;
  } cmd_word_t;

  typedef struct packed {
    logic       decided_class;
    logic [1:0] region_first;
    logic [1:0] region_second;
    cnt_t       count_first;
    cnt_t       count_second;
    cnt_t       size_first;
    cnt_t       size_second;
    logic       overflowed;
  } rsp_word_t;

  typedef struct packed {
    logic  clear;
    logic  load;
    logic  start;
    logic  prep;
    logic  rd_en;
    addr_t rd_addr;
  } unit_ctl_t;

  typedef struct packed {
    cnt_t       n;
    logic       full;
    logic [1:0] region;
    cnt_t       hits;
  } unit_stat_t;

endpackage

### rtl/qnbc_if.sv
// ----------------------------------------------------------------------------
// Quadrant naive Bayes classifier channels
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface qnbc_cmd_if;
  logic                 valid;
  logic                 ready;
  qnbc_pkg::cmd_word_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface qnbc_rsp_if;
  logic                 valid;
  logic                 ready;
  qnbc_pkg::rsp_word_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### rtl/qnbc_ram.sv
// ----------------------------------------------------------------------------
// Quadrant naive Bayes classifier RAM
// Simple dual-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module qnbc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/qnbc_class_unit.sv
// ----------------------------------------------------------------------------
// Quadrant naive Bayes classifier class unit
// Point store, fill count and bounding box of one class, plus the quadrant
// counter that runs over the stored points during a classify.
// ----------------------------------------------------------------------------
module qnbc_class_unit (
  input  logic                   clk,
  input  logic                   rst,
  input  qnbc_pkg::unit_ctl_t    ctl,
  input  qnbc_pkg::point_t       pt,
  output qnbc_pkg::unit_stat_t   stat
);
  import qnbc_pkg::*;

  cnt_t       n;
  box_t       box;
  point_t     query;
  coord_t     mid_x;
  coord_t     mid_y;
  logic [1:0] region;
  cnt_t       hits;
  logic       rd_vld;
  logic       full;
  logic       we;
  point_t     rd_point;
  coord_t     mid_x_next;
  coord_t     mid_y_next;

  function automatic coord_t midpoint(coord_t a, coord_t b);
    logic signed [COORD_BITS:0] sum;
    logic signed [COORD_BITS:0] half;
    begin
      sum  = {a[COORD_BITS-1], a} + {b[COORD_BITS-1], b};
      half = sum >>> 1;
      if (sum[COORD_BITS] && sum[0]) begin
        half = half + (COORD_BITS+1)'(1);
      end
      midpoint = half[COORD_BITS-1:0];
    end
  endfunction

  function automatic logic [1:0] quadrant(box_t b, coord_t mx, coord_t my, point_t p);
    logic [1:0] q;
    begin
      if (p.x >= b.xmin && p.x <= mx && p.y >= my && p.y <= b.ymax) begin
        q = REGION_UPPER_LEFT;
      end else if (p.x >= mx && p.x <= b.xmax && p.y >= my && p.y <= b.ymax) begin
        q = REGION_UPPER_RIGHT;
      end else if (p.x >= mx && p.x <= b.xmax && p.y >= b.ymin && p.y <= my) begin
        q = REGION_LOWER_RIGHT;
      end else begin
        q = REGION_OTHER;
      end
      quadrant = q;
    end
  endfunction

  assign full       = (n == CNT_BITS'(POINTS_PER_CLASS));
  assign we         = ctl.load && !full;
  assign mid_x_next = midpoint(box.xmin, box.xmax);
  assign mid_y_next = midpoint(box.ymin, box.ymax);

  qnbc_ram #(
    .WIDTH ($bits(point_t)),
    .DEPTH (POINTS_PER_CLASS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (n[ADDR_BITS-1:0]),
    .wdata (pt),
    .re    (ctl.rd_en),
    .raddr (ctl.rd_addr),
    .rdata (rd_point)
  );

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      n        <= '0;
      box.xmin <= COORD_MAX;
      box.ymin <= COORD_MAX;
      box.xmax <= COORD_MIN;
      box.ymax <= COORD_MIN;
      rd_vld   <= 1'b0;
      hits     <= '0;
    end else begin
      if (we) begin
        n <= n + CNT_BITS'(1);
        if (pt.x < box.xmin) box.xmin <= pt.x;
        if (pt.x > box.xmax) box.xmax <= pt.x;
        if (pt.y < box.ymin) box.ymin <= pt.y;
        if (pt.y > box.ymax) box.ymax <= pt.y;
      end
      rd_vld <= ctl.rd_en && (CNT_BITS'(ctl.rd_addr) < n);
      if (ctl.prep) begin
        hits <= '0;
      end else if (rd_vld && quadrant(box, mid_x, mid_y, rd_point) == region) begin
        hits <= hits + CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      query <= pt;
    end
    if (ctl.prep) begin
      mid_x  <= mid_x_next;
      mid_y  <= mid_y_next;
      region <= quadrant(box, mid_x_next, mid_y_next, query);
    end
  end

  assign stat.n      = n;
  assign stat.full   = full;
  assign stat.region = region;
  assign stat.hits   = hits;

endmodule

### rtl/quadrant_naive_bayes_classifier.sv
// ----------------------------------------------------------------------------
// Quadrant naive Bayes classifier
// Two-class classifier that counts training points in the query's quadrant
// of each class's bounding box.
// ----------------------------------------------------------------------------
// A load or clear word gives no result. A classify word goes through these
// steps before its result is registered: the accept latches the query,
// S_PREP computes midpoints and query quadrants, S_SCAN reads both class
// memories one entry per cycle in parallel (skipped when both classes are
// empty), S_DRAIN finishes the last count, and S_DONE registers the result
// word. S_DONE repeats while an earlier result word is still waiting to be
// taken. A new word is accepted only between classifies. The stores need no
// clearing pass.
module quadrant_naive_bayes_classifier (
  input  logic        clk,
  input  logic        rst,
  qnbc_cmd_if.sink    cmd,
  qnbc_rsp_if.source  rsp
);
  import qnbc_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREP  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  addr_t      addr;
  addr_t      addr_next;
  logic       overflowed;
  logic       accept;
  logic       is_load;
  logic       is_clear;
  logic       is_classify;
  logic       scan_end;
  logic       out_free;
  logic       first_wins;
  unit_ctl_t  ctl_first;
  unit_ctl_t  ctl_second;
  unit_stat_t stat_first;
  unit_stat_t stat_second;
  point_t     pt;
  cnt_t       addr_inc;

  assign cmd.ready   = (state == S_IDLE);
  assign accept      = cmd.valid && cmd.ready;
  assign is_load     = accept && (cmd.payload.command == CMD_LOAD);
  assign is_clear    = accept && (cmd.payload.command == CMD_CLEAR);
  assign is_classify = accept && (cmd.payload.command == CMD_CLASSIFY);
  assign pt.x        = cmd.payload.coord_x;
  assign pt.y        = cmd.payload.coord_y;
  assign addr_inc    = CNT_BITS'(addr) + CNT_BITS'(1);
  assign scan_end    = (addr_inc >= stat_first.n) && (addr_inc >= stat_second.n);
  assign out_free    = !rsp.valid || rsp.ready;
  assign first_wins  = (stat_first.n != '0) && (stat_second.n != '0)
                       && (stat_first.hits > stat_second.hits);

  always_comb begin
    ctl_first.clear   = is_clear;
    ctl_first.load    = is_load && !cmd.payload.class_label;
    ctl_first.start   = is_classify;
    ctl_first.prep    = (state == S_PREP);
    ctl_first.rd_en   = (state == S_SCAN);
    ctl_first.rd_addr = addr;
    ctl_second        = ctl_first;
    ctl_second.load   = is_load && cmd.payload.class_label;
  end

  qnbc_class_unit u_first (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl_first),
    .pt   (pt),
    .stat (stat_first)
  );

  qnbc_class_unit u_second (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl_second),
    .pt   (pt),
    .stat (stat_second)
  );

  always_comb begin
    state_next = state;
    addr_next  = addr;
    case (state)
      S_IDLE: begin
        if (is_classify) state_next = S_PREP;
      end
      S_PREP: begin
        addr_next = '0;
        if (stat_first.n == '0 && stat_second.n == '0) begin
          state_next = S_DRAIN;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          state_next = S_DRAIN;
        end else begin
          addr_next = addr + ADDR_BITS'(1);
        end
      end
      S_DRAIN: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      addr       <= '0;
      overflowed <= 1'b0;
      rsp.valid  <= 1'b0;
    end else begin
      state <= state_next;
      addr  <= addr_next;
      if (is_clear) begin
        overflowed <= 1'b0;
      end else if ((ctl_first.load && stat_first.full)
                   || (ctl_second.load && stat_second.full)) begin
        overflowed <= 1'b1;
      end
      if (state == S_DONE && out_free) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      rsp.payload.decided_class <= !first_wins;
      rsp.payload.region_first  <= stat_first.region;
      rsp.payload.region_second <= stat_second.region;
      rsp.payload.count_first   <= stat_first.hits;
      rsp.payload.count_second  <= stat_second.hits;
      rsp.payload.size_first    <= stat_first.n;
      rsp.payload.size_second   <= stat_second.n;
      rsp.payload.overflowed    <= overflowed;
    end
  end

endmodule

### rtl/qnbc_checker.sv
// ----------------------------------------------------------------------------
// Quadrant naive Bayes classifier checker
// Port-level assertions on the command and result channels.
// ----------------------------------------------------------------------------
module qnbc_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   cmd_valid,
  input logic                   cmd_ready,
  input logic [1:0]             cmd_command,
  input logic                   rsp_valid,
  input logic                   rsp_ready,
  input qnbc_pkg::rsp_word_t    rsp_payload
);
  import qnbc_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
    else $error("Result word dropped or changed while stalled.");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("Result word valid right after reset.");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && cmd_command == CMD_CLASSIFY |=> !cmd_ready)
    else $error("Command word taken while a classify is running.");

  a_first_wins: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_payload.decided_class |->
      rsp_payload.count_first > rsp_payload.count_second
      && rsp_payload.size_first != '0 && rsp_payload.size_second != '0)
    else $error("First class chosen without a strictly larger count.");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_payload.count_first <= rsp_payload.size_first
      && rsp_payload.count_second <= rsp_payload.size_second)
    else $error("Quadrant count exceeds the class size.");

endmodule

bind quadrant_naive_bayes_classifier qnbc_checker u_qnbc_checker (
  .clk         (clk),
  .rst         (rst),
  .cmd_valid   (cmd.valid),
  .cmd_ready   (cmd.ready),
  .cmd_command (cmd.payload.command),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_payload (rsp.payload)
);
